FILE: src/u8d_pkg.sv
// Shared widths, byte-class boundaries and payload masks of the UTF-8 stream decoder.
// No dependencies; used by the interfaces, the core and the checker.
package u8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 31;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned BITS_PER_CONT = 6;

  localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'h7F;
  localparam logic [BYTE_W-1:0] CONT_MIN   = 8'h80;
  localparam logic [BYTE_W-1:0] CONT_MAX   = 8'hBF;
  localparam logic [BYTE_W-1:0] LEAD2_MIN  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD2_MAX  = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_MIN  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_MAX  = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD4_MIN  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_MAX  = 8'hF7;
  localparam logic [BYTE_W-1:0] LEAD5_MIN  = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD5_MAX  = 8'hFB;
  localparam logic [BYTE_W-1:0] LEAD6_MIN  = 8'hFC;
  localparam logic [BYTE_W-1:0] LEAD6_MAX  = 8'hFD;
  localparam logic [BYTE_W-1:0] BAD_MIN    = 8'hFE;

  localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'h1F;
  localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'h0F;
  localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'h07;
  localparam logic [BYTE_W-1:0] MASK_LEAD5 = 8'h03;
  localparam logic [BYTE_W-1:0] MASK_LEAD6 = 8'h01;

  typedef enum logic {
    STATUS_OK    = 1'b0,
    STATUS_ERROR = 1'b1
  } status_t;

endpackage

FILE: src/u8d_byte_if.sv
// Valid/ready channel carrying one raw byte of the UTF-8 stream.
// Depends on u8d_pkg for the byte width.
interface u8d_byte_if;
  logic                        valid;
  logic                        ready;
  logic [u8d_pkg::BYTE_W-1:0]  in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

FILE: src/u8d_cp_if.sv
// Valid/ready channel carrying one decoded code point and its status.
// Depends on u8d_pkg for the code point width.
interface u8d_cp_if;
  logic                      valid;
  logic                      ready;
  logic [u8d_pkg::CP_W-1:0]  code_point;
  logic                      status;

  modport source (output valid, output code_point, output status, input ready);
  modport sink (input valid, input code_point, input status, output ready);
endinterface

FILE: src/utf8_stream_decoder_core.sv
// UTF-8 stream decoder core: turns a stream of bytes into code points (six-byte scheme).
// Depends on u8d_pkg, u8d_byte_if and u8d_cp_if.
//
// The bytes channel takes one byte per transaction; the chars channel gives one
// code point with a status bit per transaction. An ASCII byte and the last byte
// of a sequence each give a valid character, a lead byte and an inner continuation
// byte give nothing, and a misplaced byte gives an error with a code point of zero.
// Overlong forms are decoded as they stand.
// A byte is decoded in the cycle in which it is accepted and its result sits in the
// output register from the next cycle; one byte can be accepted in every cycle in
// which that register is empty or being read. The decoder holds only the sequence
// state and the output register; while a result waits, the next byte is still taken
// if that register is emptied in the same cycle, otherwise ready drops until it is.
// Reset clears the open sequence and empties the output register.
module utf8_stream_decoder_core (
  input  logic           clk,
  input  logic           rst,
  u8d_byte_if.sink       bytes,
  u8d_cp_if.source       chars
);

  logic [u8d_pkg::CP_W-1:0]   accumulator;
  logic [u8d_pkg::CP_W-1:0]   accumulator_next;
  logic [u8d_pkg::CNT_W-1:0]  bytes_remaining;
  logic [u8d_pkg::CNT_W-1:0]  bytes_remaining_next;
  logic                       out_valid;
  logic [u8d_pkg::CP_W-1:0]   out_code_point;
  logic                       out_status;

  logic                       accept;
  logic                       emit;
  logic [u8d_pkg::CP_W-1:0]   emit_code_point;
  u8d_pkg::status_t           emit_status;
  logic [u8d_pkg::BYTE_W-1:0] b;
  logic [u8d_pkg::CP_W-1:0]   shifted;

  assign b            = bytes.in_byte;
  assign bytes.ready  = !out_valid || chars.ready;
  assign accept       = bytes.valid && bytes.ready;
  assign shifted      = {accumulator[u8d_pkg::CP_W-u8d_pkg::BITS_PER_CONT-1:0],
                         b[u8d_pkg::BITS_PER_CONT-1:0]};

  always_comb begin
    accumulator_next     = accumulator;
    bytes_remaining_next = bytes_remaining;
    emit                 = 1'b0;
    emit_code_point      = '0;
    emit_status          = u8d_pkg::STATUS_OK;
    if (bytes_remaining == '0) begin
      unique case (b) inside
        [8'h00:u8d_pkg::ASCII_MAX]: begin
          emit            = 1'b1;
          emit_code_point = u8d_pkg::CP_W'(b);
        end
        [u8d_pkg::LEAD2_MIN:u8d_pkg::LEAD2_MAX]: begin
          accumulator_next     = u8d_pkg::CP_W'(b & u8d_pkg::MASK_LEAD2);
          bytes_remaining_next = u8d_pkg::CNT_W'(1);
        end
        [u8d_pkg::LEAD3_MIN:u8d_pkg::LEAD3_MAX]: begin
          accumulator_next     = u8d_pkg::CP_W'(b & u8d_pkg::MASK_LEAD3);
          bytes_remaining_next = u8d_pkg::CNT_W'(2);
        end
        [u8d_pkg::LEAD4_MIN:u8d_pkg::LEAD4_MAX]: begin
          accumulator_next     = u8d_pkg::CP_W'(b & u8d_pkg::MASK_LEAD4);
          bytes_remaining_next = u8d_pkg::CNT_W'(3);
        end
        [u8d_pkg::LEAD5_MIN:u8d_pkg::LEAD5_MAX]: begin
          accumulator_next     = u8d_pkg::CP_W'(b & u8d_pkg::MASK_LEAD5);
          bytes_remaining_next = u8d_pkg::CNT_W'(4);
        end
        [u8d_pkg::LEAD6_MIN:u8d_pkg::LEAD6_MAX]: begin
          accumulator_next     = u8d_pkg::CP_W'(b & u8d_pkg::MASK_LEAD6);
          bytes_remaining_next = u8d_pkg::CNT_W'(5);
        end
        default: begin
          emit        = 1'b1;
          emit_status = u8d_pkg::STATUS_ERROR;
        end
      endcase
    end else if (b >= u8d_pkg::CONT_MIN && b <= u8d_pkg::CONT_MAX) begin
      bytes_remaining_next = bytes_remaining - u8d_pkg::CNT_W'(1);
      if (bytes_remaining == u8d_pkg::CNT_W'(1)) begin
        accumulator_next = '0;
        emit             = 1'b1;
        emit_code_point  = shifted;
      end else begin
        accumulator_next = shifted;
      end
    end else begin
      accumulator_next     = '0;
      bytes_remaining_next = '0;
      emit                 = 1'b1;
      emit_status          = u8d_pkg::STATUS_ERROR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator     <= '0;
      bytes_remaining <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        accumulator     <= accumulator_next;
        bytes_remaining <= bytes_remaining_next;
      end
      if (accept && emit) begin
        out_valid <= 1'b1;
      end else if (chars.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_code_point <= emit_code_point;
      out_status     <= emit_status;
    end
  end

  assign chars.valid      = out_valid;
  assign chars.code_point = out_code_point;
  assign chars.status     = out_status;

endmodule

FILE: src/u8d_checker.sv
// Port-level assertions for the UTF-8 stream decoder core, with the bind that attaches them.
// Depends on u8d_pkg and on utf8_stream_decoder_core.
module u8d_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [u8d_pkg::BYTE_W-1:0] in_byte,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [u8d_pkg::CP_W-1:0]   code_point,
  input logic                       status
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("A result was shown in the cycle after reset.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_point) && $stable(status))
    else $error("A stalled result transaction changed or was dropped.");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("A byte was offered room while the result register was full and stalled.");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == u8d_pkg::STATUS_ERROR |-> code_point == '0)
    else $error("An error result carried a non-zero code point.");

  a_bad_byte_error: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_byte >= u8d_pkg::BAD_MIN
      |=> out_valid && status == u8d_pkg::STATUS_ERROR)
    else $error("An invalid byte did not give an error result.");

endmodule

bind utf8_stream_decoder_core u8d_checker u_u8d_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (bytes.valid),
  .in_ready   (bytes.ready),
  .in_byte    (bytes.in_byte),
  .out_valid  (chars.valid),
  .out_ready  (chars.ready),
  .code_point (chars.code_point),
  .status     (chars.status)
);
